// ===== rtl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants of the bitmap ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int DEPTH   = 1024;
    localparam int AW      = $clog2(DEPTH);
    localparam int WORD_W  = 32;
    localparam int BW      = $clog2(WORD_W);
    localparam int WORDS   = DEPTH / WORD_W;
    localparam int WA      = AW - BW;
    localparam int CNT_W   = 11;
    localparam int ID_W    = 32;
    localparam int CFG_AW  = 2;

    typedef logic [1:0] t_req;
    localparam t_req REQ_ALLOC = 2'd0;
    localparam t_req REQ_FREE  = 2'd1;
    localparam t_req REQ_INIT  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFREE  = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_TABLE_ENTRIES = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TOP_RSV       = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BOT_RSV       = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_TAG_MASK      = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] table_entries;
        logic [9:0]       top_rsv;
        logic [CNT_W-1:0] bot_rsv;
        logic [ID_W-1:0]  tag_mask;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [WA-1:0]     waddr;
        logic [WORD_W-1:0] wdata;
        logic [WA-1:0]     raddr;
    } t_mem_req;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FF     = 9'b000000010,
        S_RD     = 9'b000000100,
        S_RND    = 9'b000001000,
        S_CHK    = 9'b000010000,
        S_RMW_RD = 9'b000100000,
        S_RMW_WR = 9'b001000000,
        S_INIT   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

endpackage

// ===== rtl/bia_ifs.sv =====
// ----------------------------------------------------------------------------
// bia interfaces
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface bia_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [bia_pkg::CNT_W-1:0] count;
    logic [bia_pkg::CNT_W-1:0] alignment;
    logic [bia_pkg::ID_W-1:0]  release_id;
    logic                      round_robin;
    modport source (output valid, req_type, count, alignment, release_id, round_robin,
                    input ready);
    modport sink (input valid, req_type, count, alignment, release_id, round_robin,
                  output ready);
endinterface

interface bia_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [bia_pkg::ID_W-1:0] object_id;
    modport source (output valid, status, object_id, input ready);
    modport sink (input valid, status, object_id, output ready);
endinterface

interface bia_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bia_pkg::CFG_AW-1:0] addr;
    logic [bia_pkg::ID_W-1:0]   data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Hands out object IDs from a 1024-entry bitmap held in a word RAM.
//
// Channels: i_req carries one request per transaction (allocate, free, init),
// o_rsp returns exactly one status and object ID per request, i_cfg writes
// the four configuration registers (always ready; the user must write them
// only while idle, the block does not enforce it). One request is in work at
// a time; i_req is ready again once the response sits in the output register,
// so the next request can be taken while the receiver stalls on the previous response.
// Steps: an unknown request or invalid init goes straight to the response; init
// writes every RAM word; free read-modify-writes each touched 32-bit word;
// allocate scans one bit per cycle, pausing per RAM word fetched and per aligned
// candidate, up to two passes over the table, then read-modify-writes each word marked.
// The search speed is set by the single RAM read port and the one-bit step.
// Reset clears the bitmap (words never written read as zero), the search
// pointer, the tag and the configuration to its defaults.
// ----------------------------------------------------------------------------
module bitmap_id_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bia_req_if.sink   i_req,
    bia_rsp_if.source o_rsp,
    bia_cfg_if.sink   i_cfg
);
    bia_pkg::t_cfg              r_cfg;
    bia_pkg::t_mem_req          mem_req;
    logic [bia_pkg::WORD_W-1:0] mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_entries <= bia_pkg::CNT_W'(bia_pkg::DEPTH);
            r_cfg.top_rsv       <= '0;
            r_cfg.bot_rsv       <= '0;
            r_cfg.tag_mask      <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                bia_pkg::CFG_TABLE_ENTRIES: r_cfg.table_entries <= i_cfg.data[10:0];
                bia_pkg::CFG_TOP_RSV:       r_cfg.top_rsv       <= i_cfg.data[9:0];
                bia_pkg::CFG_BOT_RSV:       r_cfg.bot_rsv       <= i_cfg.data[10:0];
                bia_pkg::CFG_TAG_MASK:      r_cfg.tag_mask      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    bia_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata)
    );
endmodule

// ===== rtl/bia_mem.sv =====
// ----------------------------------------------------------------------------
// bia_mem
// Bitmap word RAM, one write and one registered read port; words that were
// never written read as zero.
// ----------------------------------------------------------------------------
module bia_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bia_pkg::t_mem_req              i_req,
    output logic [bia_pkg::WORD_W-1:0]     o_rdata
);
    logic [bia_pkg::WORD_W-1:0] r_mem [bia_pkg::WORDS];
    logic [bia_pkg::WORDS-1:0]  r_vld;
    logic [bia_pkg::WORD_W-1:0] r_rdata;
    logic                       r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;
endmodule

// ===== rtl/bia_ctrl.sv =====
// ----------------------------------------------------------------------------
// bia_ctrl
// Request sequencer: next-fit search, range marking and clearing, table init.
// ----------------------------------------------------------------------------
module bia_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bia_pkg::t_cfg               i_cfg,
    bia_req_if.sink                     i_req,
    bia_rsp_if.source                   o_rsp,
    output bia_pkg::t_mem_req           o_mem,
    input  logic [bia_pkg::WORD_W-1:0]  i_mem_rdata
);
    localparam int CW = bia_pkg::CNT_W;
    localparam int AW = bia_pkg::AW;
    localparam int BW = bia_pkg::BW;
    localparam int WA = bia_pkg::WA;
    localparam int IW = bia_pkg::ID_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(bia_pkg::DEPTH);

    bia_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]   r_cnt, n_cnt, r_amask, n_amask, r_p, n_p, r_idx, n_idx;
    logic [CW-1:0]   r_end, n_end, r_lo, n_lo, r_hi, n_hi;
    logic            r_single, n_single, r_pass, n_pass, r_set, n_set;
    logic [AW-1:0]   r_ns, n_ns;
    logic [IW-1:0]   r_tag, n_tag, r_oid, n_oid;
    logic [1:0]      r_st, n_st;
    logic [bia_pkg::WORD_W-1:0] r_cw, n_cw;
    logic [WA-1:0]   r_cw_idx, n_cw_idx, r_w, n_w;
    logic            r_cw_ok, n_cw_ok;
    logic            r_ovld, n_ovld;
    logic [1:0]      r_ost, n_ost;
    logic [IW-1:0]   r_ooid, n_ooid;

    logic [CW-1:0]   ncap, m;
    logic [IW-1:0]   tag_rot;
    logic            hit, bitv;
    logic [bia_pkg::WORD_W-1:0] rmask;

    function automatic logic [bia_pkg::WORD_W-1:0] range_mask(
        input logic [WA-1:0] w, input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        logic [bia_pkg::WORD_W-1:0] mk;
        logic [CW-1:0] pos;
        mk = '0;
        for (int b = 0; b < bia_pkg::WORD_W; b++) begin
            pos = {1'b0, w, BW'(b)};
            mk[b] = (pos >= lo) && (pos < hi);
        end
        return mk;
    endfunction

    assign ncap    = (i_cfg.table_entries > DEPTH_C) ? DEPTH_C : i_cfg.table_entries;
    assign m       = ({1'b0, i_cfg.top_rsv} >= ncap) ? '0
                     : ncap - {1'b0, i_cfg.top_rsv};
    assign tag_rot = (r_tag + {{(IW-CW){1'b0}}, m}
                      + {{(IW-10){1'b0}}, i_cfg.top_rsv}) & i_cfg.tag_mask;
    assign hit     = r_cw_ok && (r_cw_idx == r_p[AW-1:BW]);
    assign bitv    = r_cw[r_p[BW-1:0]];
    assign rmask   = range_mask(r_w, r_lo, r_hi);

    assign i_req.ready     = (r_state == bia_pkg::S_IDLE);
    assign o_rsp.valid     = r_ovld;
    assign o_rsp.status    = r_ost;
    assign o_rsp.object_id = r_ooid;

    always_comb begin
        logic [CW-1:0] align1, hm1, obj, nx;
        logic [CW:0]   sum12, idx12, ecnt;
        logic [CW+1:0] end13;
        logic [IW-1:0] fmask, base;
        logic [IW:0]   fend;
        n_state = r_state; n_ret = r_ret; n_cnt = r_cnt; n_amask = r_amask;
        n_p = r_p; n_idx = r_idx; n_end = r_end; n_lo = r_lo; n_hi = r_hi;
        n_single = r_single; n_pass = r_pass; n_set = r_set; n_ns = r_ns;
        n_tag = r_tag; n_oid = r_oid; n_st = r_st; n_cw = r_cw;
        n_cw_idx = r_cw_idx; n_w = r_w; n_cw_ok = r_cw_ok;
        n_ovld = r_ovld; n_ost = r_ost; n_ooid = r_ooid;
        o_mem.we = 1'b0; o_mem.waddr = r_w; o_mem.wdata = '0;
        o_mem.raddr = r_p[AW-1:BW];
        align1 = (i_req.alignment == '0) ? CW'(1) : i_req.alignment;
        sum12 = {1'b0, r_idx} + {1'b0, r_amask};
        idx12 = sum12 & ~{1'b0, r_amask};
        end13 = {1'b0, idx12} + {2'b0, r_cnt};
        hm1 = r_hi - CW'(1);
        obj = r_idx;
        nx = obj + CW'(1);
        ecnt = {1'b0, obj} + {1'b0, r_cnt};
        fmask = {{(IW-CW){1'b0}}, m} + {{(IW-10){1'b0}}, i_cfg.top_rsv} - IW'(1);
        base = i_req.release_id & fmask;
        fend = {1'b0, base} + {{(IW+1-CW){1'b0}}, i_req.count};

        if (o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            bia_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_cw_ok = 1'b0;
                    n_cnt = i_req.count;
                    n_st = bia_pkg::ST_OK;
                    n_oid = '0;
                    case (i_req.req_type)
                        bia_pkg::REQ_ALLOC: begin
                            n_amask = align1 - CW'(1);
                            n_single = (i_req.count == CW'(1)) && (align1 == CW'(1));
                            n_p = {1'b0, r_ns};
                            n_pass = 1'b0;
                            n_state = bia_pkg::S_FF;
                        end
                        bia_pkg::REQ_FREE: begin
                            if (!i_req.round_robin && (base < {{(IW-AW){1'b0}}, r_ns})) begin
                                n_ns = base[AW-1:0];
                            end
                            n_tag = tag_rot;
                            n_set = 1'b0;
                            n_lo = base[CW-1:0];
                            n_hi = (fend > {{(IW+1-CW){1'b0}}, DEPTH_C}) ? DEPTH_C
                                   : fend[CW-1:0];
                            n_w = base[AW-1:BW];
                            if (i_req.count == '0
                                || base >= {{(IW-CW){1'b0}}, DEPTH_C}) begin
                                n_state = bia_pkg::S_OUT;
                            end else begin
                                n_state = bia_pkg::S_RMW_RD;
                            end
                        end
                        bia_pkg::REQ_INIT: begin
                            if (i_cfg.table_entries == '0
                                || (i_cfg.table_entries
                                    & (i_cfg.table_entries - CW'(1))) != '0
                                || i_cfg.table_entries > DEPTH_C) begin
                                n_st = bia_pkg::ST_INVALID;
                                n_state = bia_pkg::S_OUT;
                            end else begin
                                n_ns = '0;
                                n_tag = '0;
                                n_lo = '0;
                                n_hi = (i_cfg.bot_rsv > DEPTH_C) ? DEPTH_C
                                       : i_cfg.bot_rsv;
                                n_w = '0;
                                n_state = bia_pkg::S_INIT;
                            end
                        end
                        default: begin
                            n_state = bia_pkg::S_OUT;
                        end
                    endcase
                end
            end
            bia_pkg::S_FF: begin
                if (r_p >= m) begin
                    n_idx = r_p;
                    n_state = bia_pkg::S_RND;
                end else if (!hit) begin
                    n_ret = bia_pkg::S_FF;
                    n_state = bia_pkg::S_RD;
                end else if (!bitv) begin
                    n_idx = r_p;
                    n_state = bia_pkg::S_RND;
                end else begin
                    n_p = r_p + CW'(1);
                end
            end
            bia_pkg::S_RD: begin
                n_cw = i_mem_rdata;
                n_cw_idx = r_p[AW-1:BW];
                n_cw_ok = 1'b1;
                n_state = r_ret;
            end
            bia_pkg::S_RND: begin
                if (end13 > {2'b0, m} || idx12 >= {1'b0, m}) begin
                    if (!r_pass) begin
                        n_tag = tag_rot;
                        n_pass = 1'b1;
                        n_p = '0;
                        n_state = bia_pkg::S_FF;
                    end else begin
                        n_st = bia_pkg::ST_NOFREE;
                        n_state = bia_pkg::S_OUT;
                    end
                end else begin
                    n_idx = idx12[CW-1:0];
                    n_end = end13[CW-1:0];
                    n_p = idx12[CW-1:0];
                    n_state = bia_pkg::S_CHK;
                end
            end
            bia_pkg::S_CHK: begin
                if (r_p == r_end) begin
                    n_oid = {{(IW-CW){1'b0}}, obj} | r_tag;
                    if (r_single) begin
                        n_ns = (nx == m) ? '0 : nx[AW-1:0];
                    end else if (obj[AW-1:0] == r_ns) begin
                        n_ns = (ecnt >= {1'b0, m}) ? '0 : ecnt[AW-1:0];
                    end
                    n_set = 1'b1;
                    n_lo = obj;
                    n_hi = ecnt[CW-1:0];
                    n_w = obj[AW-1:BW];
                    n_state = (r_cnt == '0) ? bia_pkg::S_OUT : bia_pkg::S_RMW_RD;
                end else if (!hit) begin
                    n_ret = bia_pkg::S_CHK;
                    n_state = bia_pkg::S_RD;
                end else if (bitv) begin
                    n_p = r_p + CW'(1);
                    n_state = bia_pkg::S_FF;
                end else begin
                    n_p = r_p + CW'(1);
                end
            end
            bia_pkg::S_RMW_RD: begin
                o_mem.raddr = r_w;
                n_state = bia_pkg::S_RMW_WR;
            end
            bia_pkg::S_RMW_WR: begin
                o_mem.we = 1'b1;
                o_mem.wdata = r_set ? (i_mem_rdata | rmask) : (i_mem_rdata & ~rmask);
                if (r_w == hm1[AW-1:BW]) begin
                    n_state = bia_pkg::S_OUT;
                end else begin
                    n_w = r_w + WA'(1);
                    n_state = bia_pkg::S_RMW_RD;
                end
            end
            bia_pkg::S_INIT: begin
                o_mem.we = 1'b1;
                o_mem.wdata = rmask;
                if (r_w == WA'(bia_pkg::WORDS - 1)) begin
                    n_state = bia_pkg::S_OUT;
                end else begin
                    n_w = r_w + WA'(1);
                end
            end
            bia_pkg::S_OUT: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld = 1'b1;
                    n_ost = r_st;
                    n_ooid = r_oid;
                    n_state = bia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bia_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bia_pkg::S_IDLE;
            r_ret   <= bia_pkg::S_FF;
            r_ns    <= '0;
            r_tag   <= '0;
            r_cw_ok <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ns    <= n_ns;
            r_tag   <= n_tag;
            r_cw_ok <= n_cw_ok;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt; r_amask <= n_amask; r_p <= n_p; r_idx <= n_idx;
        r_end <= n_end; r_lo <= n_lo; r_hi <= n_hi; r_single <= n_single;
        r_pass <= n_pass; r_set <= n_set; r_oid <= n_oid; r_st <= n_st;
        r_cw <= n_cw; r_cw_idx <= n_cw_idx; r_w <= n_w;
        r_ost <= n_ost; r_ooid <= n_ooid;
    end
endmodule

// ===== rtl/bia_checker.sv =====
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the allocator response channel.
// ----------------------------------------------------------------------------
module bia_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_object_id,
    input logic        i_req_valid,
    input logic        i_req_ready
);
    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
        && $stable(i_rsp_object_id))
        else $error("response changed while stalled");

    // failed requests never grant an id
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bia_pkg::ST_OK |-> i_rsp_object_id == 32'd0)
        else $error("nonzero id with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status <= bia_pkg::ST_INVALID)
        else $error("undefined status code");

    // requests are never taken back to back
    a_no_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken back to back");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_object_id (o_rsp.object_id),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready)
);
